### design/acn_pkg.sv
// ----------------------------------------------------------------------------
// acn_pkg
// Shared widths, sideband structs and single-step helpers for the arc centre
// and midpoint pipeline.
// ----------------------------------------------------------------------------
package acn_pkg;

    localparam int COORD_W  = 32;   // coordinate field
    localparam int RAD_W    = 31;   // radius field
    localparam int MAG_W    = 32;   // |dx|, |dy|
    localparam int SUM2_W   = 34;   // 2*(a+b)
    localparam int SQ_W     = 64;   // squares, radicands
    localparam int ROOT_W   = 32;   // square roots
    localparam int K_W      = 5;    // normalising exponent, 0..30 (31 for a zero chord)
    localparam int PROD_W   = 64;   // L*a
    localparam int NUM_W    = 95;   // L*a << (k+1)
    localparam int QUO_W    = 36;   // quotient bits
    localparam int Q_W      = 38;   // 4x result before rounding
    localparam int SQ_LANES  = 2;
    localparam int DIV_LANES = 4;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_SAME   = 2'd1,
        ERR_RADIUS = 2'd2
    } err_t;

    // travels alongside the square-root stages
    typedef struct packed {
        logic signed [SUM2_W-1:0] sumx2;
        logic signed [SUM2_W-1:0] sumy2;
        logic                     ngx;
        logic                     ngy;
        logic                     cw;
        err_t                     err;
        logic [RAD_W-1:0]         r;
        logic [MAG_W-1:0]         adx;
        logic [MAG_W-1:0]         ady;
        logic [K_W-1:0]           k;
    } side_a_t;

    // travels alongside the divider stages
    typedef struct packed {
        logic signed [SUM2_W-1:0] sumx2;
        logic signed [SUM2_W-1:0] sumy2;
        logic                     ngx;
        logic                     ngy;
        logic                     cw;
        err_t                     err;
    } side_b_t;

    typedef struct packed {
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
    } sq_step_t;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic              qbit;
    } dv_step_t;

    // one result bit of a restoring square root
    function automatic sq_step_t sqrt_step(input logic [ROOT_W+1:0] rem,
                                           input logic [ROOT_W-1:0] root,
                                           input logic [1:0] pair);
        logic [ROOT_W+3:0] rs;
        logic [ROOT_W+3:0] tr;
        sq_step_t          o;
        rs = {rem, pair};
        tr = {2'b00, root, 2'b01};
        if (rs >= tr) begin
            o.rem  = (ROOT_W+2)'(rs - tr);
            o.root = {root[ROOT_W-2:0], 1'b1};
        end else begin
            o.rem  = rs[ROOT_W+1:0];
            o.root = {root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // one quotient bit of a restoring division
    function automatic dv_step_t div_step(input logic [ROOT_W-1:0] rem,
                                          input logic [ROOT_W-1:0] d,
                                          input logic nbit);
        logic [ROOT_W:0] rs;
        dv_step_t        o;
        rs = {rem, nbit};
        if (rs >= {1'b0, d}) begin
            o.rem  = ROOT_W'(rs - {1'b0, d});
            o.qbit = 1'b1;
        end else begin
            o.rem  = rs[ROOT_W-1:0];
            o.qbit = 1'b0;
        end
        return o;
    endfunction

endpackage

### design/arc_center_and_midpoint_top.sv
// ----------------------------------------------------------------------------
// arc_center_and_midpoint_top
// Arc centre and arc midpoint from start point, end point, radius and
// direction; flags coincident points and a radius below half the chord.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless the output stalls; the 32-stage square
// roots and the 36-stage divider each retire one bit per stage and form most of the pipeline.
// Stalls: the whole pipeline holds while the output word waits.
// Reset: aresetn (synchronous) clears every valid bit; data registers keep.
module arc_center_and_midpoint_top (
    input  logic         aclk,
    input  logic         aresetn,
    // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96],
    // radius[158:128], bit 159 zero
    input  logic [159:0] s_tdata,
    input  logic         s_tuser,    // clockwise
    input  logic         s_tvalid,
    output logic         s_tready,
    // center_x[31:0], center_y[63:32], arc_mid_x[95:64], arc_mid_y[127:96]
    output logic [127:0] m_tdata,
    output logic [1:0]   m_tuser,    // error_code
    output logic         m_tvalid,
    input  logic         m_tready
);

    localparam int CW    = acn_pkg::COORD_W;
    localparam int RW    = acn_pkg::RAD_W;
    localparam int MW    = acn_pkg::MAG_W;
    localparam int SW    = acn_pkg::SUM2_W;
    localparam int QW    = acn_pkg::SQ_W;
    localparam int TW    = acn_pkg::ROOT_W;
    localparam int KW    = acn_pkg::K_W;
    localparam int NORM  = 5;            // shift steps 16,8,4,2,1
    localparam int QT_W  = acn_pkg::QUO_W;
    localparam int QQ_W  = acn_pkg::Q_W;

    // one global advance: every stage moves when the output slot frees
    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // ---------------- field unpacking
    logic [CW-1:0] in_sx, in_sy, in_ex, in_ey;
    logic [RW-1:0] in_r;
    assign in_sx = s_tdata[31:0];
    assign in_sy = s_tdata[63:32];
    assign in_ex = s_tdata[95:64];
    assign in_ey = s_tdata[127:96];
    assign in_r  = s_tdata[158:128];

    // ---------------- S1: chord vector and doubled endpoint sums
    logic                 s1_valid_reg;
    logic signed [CW:0]   s1_dx_reg, s1_dy_reg;
    logic signed [SW-1:0] s1_sumx2_reg, s1_sumy2_reg;
    logic [RW-1:0]        s1_r_reg;
    logic                 s1_cw_reg;

    logic [CW:0] s1_sumx_next, s1_sumy_next;
    assign s1_sumx_next = {in_sx[CW-1], in_sx} + {in_ex[CW-1], in_ex};
    assign s1_sumy_next = {in_sy[CW-1], in_sy} + {in_ey[CW-1], in_ey};

    always_ff @(posedge aclk) begin
        if (!aresetn) s1_valid_reg <= 1'b0;
        else if (adv) s1_valid_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_dx_reg    <= {in_ex[CW-1], in_ex} - {in_sx[CW-1], in_sx};
            s1_dy_reg    <= {in_ey[CW-1], in_ey} - {in_sy[CW-1], in_sy};
            s1_sumx2_reg <= {s1_sumx_next, 1'b0};
            s1_sumy2_reg <= {s1_sumy_next, 1'b0};
            s1_r_reg     <= in_r;
            s1_cw_reg    <= s_tuser;
        end
    end

    // ---------------- S2: magnitudes and signs
    logic                 s2_valid_reg;
    logic [MW-1:0]        s2_adx_reg, s2_ady_reg;
    logic                 s2_ngx_reg, s2_ngy_reg, s2_zero_reg;
    logic signed [SW-1:0] s2_sumx2_reg, s2_sumy2_reg;
    logic [RW-1:0]        s2_r_reg;
    logic                 s2_cw_reg;

    logic [CW:0] s2_ndx_next, s2_ndy_next;
    assign s2_ndx_next = -s1_dx_reg;
    assign s2_ndy_next = -s1_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s2_valid_reg <= 1'b0;
        else if (adv) s2_valid_reg <= s1_valid_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_adx_reg   <= s1_dx_reg[CW] ? s2_ndx_next[MW-1:0] : s1_dx_reg[MW-1:0];
            s2_ady_reg   <= s1_dy_reg[CW] ? s2_ndy_next[MW-1:0] : s1_dy_reg[MW-1:0];
            s2_ngx_reg   <= s1_dx_reg[CW];
            s2_ngy_reg   <= s1_dy_reg[CW];
            s2_zero_reg  <= (s1_dx_reg == '0) && (s1_dy_reg == '0);
            s2_sumx2_reg <= s1_sumx2_reg;
            s2_sumy2_reg <= s1_sumy2_reg;
            s2_r_reg     <= s1_r_reg;
            s2_cw_reg    <= s1_cw_reg;
        end
    end

    // ---------------- S3: squares
    logic                 s3_valid_reg;
    logic [QW-1:0]        s3_sqx_reg, s3_sqy_reg, s3_r4_reg;
    logic [MW-1:0]        s3_adx_reg, s3_ady_reg;
    logic                 s3_ngx_reg, s3_ngy_reg, s3_zero_reg;
    logic signed [SW-1:0] s3_sumx2_reg, s3_sumy2_reg;
    logic [RW-1:0]        s3_r_reg;
    logic                 s3_cw_reg;

    logic [2*RW-1:0] s3_rr_next;
    assign s3_rr_next = s2_r_reg * s2_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s3_valid_reg <= 1'b0;
        else if (adv) s3_valid_reg <= s2_valid_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_sqx_reg   <= s2_adx_reg * s2_adx_reg;
            s3_sqy_reg   <= s2_ady_reg * s2_ady_reg;
            s3_r4_reg    <= {s3_rr_next, 2'b00};
            s3_adx_reg   <= s2_adx_reg;
            s3_ady_reg   <= s2_ady_reg;
            s3_ngx_reg   <= s2_ngx_reg;
            s3_ngy_reg   <= s2_ngy_reg;
            s3_zero_reg  <= s2_zero_reg;
            s3_sumx2_reg <= s2_sumx2_reg;
            s3_sumy2_reg <= s2_sumy2_reg;
            s3_r_reg     <= s2_r_reg;
            s3_cw_reg    <= s2_cw_reg;
        end
    end

    // ---------------- S4: chord squared, error check, 4r^2 - c^2
    logic              s4_valid_reg;
    logic [QW-1:0]     s4_dd_reg, s4_cc_reg;
    acn_pkg::side_a_t  s4_side_reg;

    logic [QW:0]       s4_cc_next;
    acn_pkg::side_a_t  s4_side_next;
    assign s4_cc_next = {1'b0, s3_sqx_reg} + {1'b0, s3_sqy_reg};

    always_comb begin
        s4_side_next.sumx2 = s3_sumx2_reg;
        s4_side_next.sumy2 = s3_sumy2_reg;
        s4_side_next.ngx   = s3_ngx_reg;
        s4_side_next.ngy   = s3_ngy_reg;
        s4_side_next.cw    = s3_cw_reg;
        s4_side_next.r     = s3_r_reg;
        s4_side_next.adx   = s3_adx_reg;
        s4_side_next.ady   = s3_ady_reg;
        s4_side_next.k     = '0;
        if (s3_zero_reg)                          s4_side_next.err = acn_pkg::ERR_SAME;
        else if (s4_cc_next > {1'b0, s3_r4_reg}) s4_side_next.err = acn_pkg::ERR_RADIUS;
        else                                      s4_side_next.err = acn_pkg::ERR_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) s4_valid_reg <= 1'b0;
        else if (adv) s4_valid_reg <= s3_valid_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_dd_reg   <= s3_r4_reg - s4_cc_next[QW-1:0];
            s4_cc_reg   <= s4_cc_next[QW-1:0];
            s4_side_reg <= s4_side_next;
        end
    end

    // ---------------- normalise nonzero c^2 below 2^62 by 4^k into [2^60, 2^62), binary search
    logic              nm_valid_reg [NORM];
    logic [QW-1:0]     nm_cc_reg    [NORM];
    logic [QW-1:0]     nm_dd_reg    [NORM];
    acn_pkg::side_a_t  nm_side_reg  [NORM];

    logic              nm_valid_next [NORM];
    logic [QW-1:0]     nm_cc_next    [NORM];
    logic [QW-1:0]     nm_dd_next    [NORM];
    acn_pkg::side_a_t  nm_side_next  [NORM];

    always_comb begin
        logic [QW-1:0]    cc_c;
        acn_pkg::side_a_t sd_c;
        int               sh;
        for (int j = 0; j < NORM; j++) begin
            sh = 16 >> j;
            if (j == 0) begin
                nm_valid_next[j] = s4_valid_reg;
                nm_dd_next[j]    = s4_dd_reg;
                cc_c             = s4_cc_reg;
                sd_c             = s4_side_reg;
            end else begin
                nm_valid_next[j] = nm_valid_reg[j-1];
                nm_dd_next[j]    = nm_dd_reg[j-1];
                cc_c             = nm_cc_reg[j-1];
                sd_c             = nm_side_reg[j-1];
            end
            if ((cc_c >> (62 - 2 * sh)) == '0) begin
                cc_c   = cc_c << (2 * sh);
                sd_c.k = sd_c.k + KW'(sh);
            end
            nm_cc_next[j]   = cc_c;
            nm_side_next[j] = sd_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NORM; j++) nm_valid_reg[j] <= 1'b0;
        end else if (adv) begin
            for (int j = 0; j < NORM; j++) nm_valid_reg[j] <= nm_valid_next[j];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < NORM; j++) begin
                nm_cc_reg[j]   <= nm_cc_next[j];
                nm_dd_reg[j]   <= nm_dd_next[j];
                nm_side_reg[j] <= nm_side_next[j];
            end
        end
    end

    // ---------------- square roots: lane 0 gives t = 2h, lane 1 gives cs
    logic [QW-1:0]     sq_rad [acn_pkg::SQ_LANES];
    logic [TW-1:0]     sq_root [acn_pkg::SQ_LANES];
    logic              sq_valid;
    acn_pkg::side_a_t  sq_side;

    assign sq_rad[0] = nm_dd_reg[NORM-1];
    assign sq_rad[1] = nm_cc_reg[NORM-1];

    acn_sqrt #(
        .SIDE_W ($bits(acn_pkg::side_a_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (nm_valid_reg[NORM-1]),
        .rad_in    (sq_rad),
        .side_in   (nm_side_reg[NORM-1]),
        .out_valid (sq_valid),
        .root_out  (sq_root),
        .side_out  (sq_side)
    );

    // ---------------- P1: v = 2r - t
    logic              p1_valid_reg;
    logic [TW-1:0]     p1_t_reg, p1_v_reg, p1_cs_reg;
    acn_pkg::side_a_t  p1_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) p1_valid_reg <= 1'b0;
        else if (adv) p1_valid_reg <= sq_valid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_t_reg    <= sq_root[0];
            p1_v_reg    <= {sq_side.r, 1'b0} - sq_root[0];
            p1_cs_reg   <= sq_root[1];
            p1_side_reg <= sq_side;
        end
    end

    // ---------------- P2: products L*a
    logic                         p2_valid_reg;
    logic [acn_pkg::PROD_W-1:0]   p2_prod_reg [acn_pkg::DIV_LANES];
    logic [TW-1:0]                p2_cs_reg;
    logic [KW-1:0]                p2_k_reg;
    acn_pkg::side_b_t             p2_side_reg;
    acn_pkg::side_b_t             p2_side_next;

    always_comb begin
        p2_side_next.sumx2 = p1_side_reg.sumx2;
        p2_side_next.sumy2 = p1_side_reg.sumy2;
        p2_side_next.ngx   = p1_side_reg.ngx;
        p2_side_next.ngy   = p1_side_reg.ngy;
        p2_side_next.cw    = p1_side_reg.cw;
        p2_side_next.err   = p1_side_reg.err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) p2_valid_reg <= 1'b0;
        else if (adv) p2_valid_reg <= p1_valid_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_prod_reg[0] <= p1_t_reg * p1_side_reg.ady;
            p2_prod_reg[1] <= p1_t_reg * p1_side_reg.adx;
            p2_prod_reg[2] <= p1_v_reg * p1_side_reg.ady;
            p2_prod_reg[3] <= p1_v_reg * p1_side_reg.adx;
            p2_cs_reg      <= p1_cs_reg;
            p2_k_reg       <= p1_side_reg.k;
            p2_side_reg    <= p2_side_next;
        end
    end

    // ---------------- P3: dividend = product << (k+1)
    logic                         p3_valid_reg;
    logic [acn_pkg::NUM_W-1:0]    p3_num_reg [acn_pkg::DIV_LANES];
    logic [TW-1:0]                p3_cs_reg;
    acn_pkg::side_b_t             p3_side_reg;
    logic [KW:0]                  p3_sh_next;

    assign p3_sh_next = {1'b0, p2_k_reg} + (KW+1)'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) p3_valid_reg <= 1'b0;
        else if (adv) p3_valid_reg <= p2_valid_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int l = 0; l < acn_pkg::DIV_LANES; l++) begin
                p3_num_reg[l] <= {(acn_pkg::NUM_W-acn_pkg::PROD_W)'(0), p2_prod_reg[l]}
                                 << p3_sh_next;
            end
            p3_cs_reg   <= p2_cs_reg;
            p3_side_reg <= p2_side_reg;
        end
    end

    // ---------------- divider: W = floor(num / cs)
    logic [QT_W-1:0]   dv_quo [acn_pkg::DIV_LANES];
    logic              dv_valid;
    acn_pkg::side_b_t  dv_side;

    acn_div #(
        .SIDE_W ($bits(acn_pkg::side_b_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (p3_valid_reg),
        .num_in    (p3_num_reg),
        .den_in    (p3_cs_reg),
        .side_in   (p3_side_reg),
        .out_valid (dv_valid),
        .quo_out   (dv_quo),
        .side_out  (dv_side)
    );

    // ---------------- F1: four times each coordinate
    logic                    f1_valid_reg;
    logic signed [QQ_W-1:0]  f1_q_reg [4];
    acn_pkg::err_t           f1_err_reg;

    logic signed [QQ_W-1:0]  f1_sx, f1_sy;
    logic signed [QQ_W-1:0]  f1_wt_y, f1_wt_x, f1_wv_y, f1_wv_x;
    logic                    f1_fy, f1_fx;

    assign f1_sx   = QQ_W'(dv_side.sumx2);
    assign f1_sy   = QQ_W'(dv_side.sumy2);
    assign f1_wt_y = {2'b00, dv_quo[0]};
    assign f1_wt_x = {2'b00, dv_quo[1]};
    assign f1_wv_y = {2'b00, dv_quo[2]};
    assign f1_wv_x = {2'b00, dv_quo[3]};
    // direction times sign of the chord component
    assign f1_fy   = dv_side.cw ^ dv_side.ngy;
    assign f1_fx   = dv_side.cw ^ dv_side.ngx;

    always_ff @(posedge aclk) begin
        if (!aresetn) f1_valid_reg <= 1'b0;
        else if (adv) f1_valid_reg <= dv_valid;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_q_reg[0] <= f1_fy ? f1_sx + f1_wt_y : f1_sx - f1_wt_y;  // centre x
            f1_q_reg[1] <= f1_fx ? f1_sy - f1_wt_x : f1_sy + f1_wt_x;  // centre y
            f1_q_reg[2] <= f1_fy ? f1_sx - f1_wv_y : f1_sx + f1_wv_y;  // mid x
            f1_q_reg[3] <= f1_fx ? f1_sy + f1_wv_x : f1_sy - f1_wv_x;  // mid y
            f1_err_reg  <= dv_side.err;
        end
    end

    // ---------------- output: round to nearest, saturate, zero on error
    function automatic logic [CW-1:0] round_sat(input logic signed [QQ_W-1:0] q);
        logic [QQ_W:0] r;
        r = {q[QQ_W-1], q} + (QQ_W+1)'(2);
        if (r[QQ_W:CW+1] == '0 || r[QQ_W:CW+1] == '1)
            return r[CW+1:2];
        else if (r[QQ_W])
            return {1'b1, (CW-1)'(0)};
        else
            return {1'b0, {(CW-1){1'b1}}};
    endfunction

    logic          m_tvalid_reg;
    logic [127:0]  m_tdata_reg, m_tdata_next;
    logic [1:0]    m_tuser_reg;

    always_comb begin
        if (f1_err_reg == acn_pkg::ERR_OK)
            m_tdata_next = {round_sat(f1_q_reg[3]), round_sat(f1_q_reg[2]),
                            round_sat(f1_q_reg[1]), round_sat(f1_q_reg[0])};
        else
            m_tdata_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else if (adv) m_tvalid_reg <= f1_valid_reg;
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= f1_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### design/acn_sqrt.sv
// ----------------------------------------------------------------------------
// acn_sqrt
// Two-lane pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module acn_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [acn_pkg::SQ_W-1:0]    rad_in [acn_pkg::SQ_LANES],
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic [acn_pkg::ROOT_W-1:0]  root_out [acn_pkg::SQ_LANES],
    output logic [SIDE_W-1:0]           side_out
);

    localparam int NST   = acn_pkg::ROOT_W;
    localparam int LANES = acn_pkg::SQ_LANES;
    localparam int RW    = acn_pkg::SQ_W;
    localparam int REM_W = acn_pkg::ROOT_W + 2;

    logic                        valid_reg  [NST];
    logic [SIDE_W-1:0]           side_reg   [NST];
    logic [RW-1:0]               rad_reg    [NST][LANES];
    logic [REM_W-1:0]            rem_reg    [NST][LANES];
    logic [acn_pkg::ROOT_W-1:0]  root_reg   [NST][LANES];

    logic                        valid_next [NST];
    logic [SIDE_W-1:0]           side_next  [NST];
    logic [RW-1:0]               rad_next   [NST][LANES];
    logic [REM_W-1:0]            rem_next   [NST][LANES];
    logic [acn_pkg::ROOT_W-1:0]  root_next  [NST][LANES];

    always_comb begin
        logic [RW-1:0]              rad_c;
        logic [REM_W-1:0]           rem_c;
        logic [acn_pkg::ROOT_W-1:0] root_c;
        acn_pkg::sq_step_t          st;
        for (int g = 0; g < NST; g++) begin
            valid_next[g] = (g == 0) ? in_valid : valid_reg[(g == 0) ? 0 : g - 1];
            side_next[g]  = (g == 0) ? side_in  : side_reg[(g == 0) ? 0 : g - 1];
            for (int l = 0; l < LANES; l++) begin
                if (g == 0) begin
                    rad_c  = rad_in[l];
                    rem_c  = '0;
                    root_c = '0;
                end else begin
                    rad_c  = rad_reg[g-1][l];
                    rem_c  = rem_reg[g-1][l];
                    root_c = root_reg[g-1][l];
                end
                st = acn_pkg::sqrt_step(rem_c, root_c, rad_c[RW-1 -: 2]);
                rad_next[g][l]  = rad_c << 2;
                rem_next[g][l]  = st.rem;
                root_next[g][l] = st.root;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NST; g++) valid_reg[g] <= 1'b0;
        end else if (adv) begin
            for (int g = 0; g < NST; g++) valid_reg[g] <= valid_next[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int g = 0; g < NST; g++) begin
                side_reg[g] <= side_next[g];
                for (int l = 0; l < LANES; l++) begin
                    rad_reg[g][l]  <= rad_next[g][l];
                    rem_reg[g][l]  <= rem_next[g][l];
                    root_reg[g][l] <= root_next[g][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign side_out  = side_reg[NST-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) root_out[l] = root_reg[NST-1][l];
    end

endmodule

### design/acn_div.sv
// ----------------------------------------------------------------------------
// acn_div
// Four-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage.
// ----------------------------------------------------------------------------
module acn_div #(
    parameter int SIDE_W = 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [acn_pkg::NUM_W-1:0]   num_in [acn_pkg::DIV_LANES],
    input  logic [acn_pkg::ROOT_W-1:0]  den_in,
    input  logic [SIDE_W-1:0]           side_in,
    output logic                        out_valid,
    output logic [acn_pkg::QUO_W-1:0]   quo_out [acn_pkg::DIV_LANES],
    output logic [SIDE_W-1:0]           side_out
);

    localparam int NST   = acn_pkg::QUO_W;
    localparam int LANES = acn_pkg::DIV_LANES;
    localparam int DW    = acn_pkg::ROOT_W;

    logic                valid_reg  [NST];
    logic [SIDE_W-1:0]   side_reg   [NST];
    logic [DW-1:0]       den_reg    [NST];
    logic [NST-1:0]      num_reg    [NST][LANES];
    logic [DW-1:0]       rem_reg    [NST][LANES];
    logic [NST-1:0]      quo_reg    [NST][LANES];

    logic                valid_next [NST];
    logic [SIDE_W-1:0]   side_next  [NST];
    logic [DW-1:0]       den_next   [NST];
    logic [NST-1:0]      num_next   [NST][LANES];
    logic [DW-1:0]       rem_next   [NST][LANES];
    logic [NST-1:0]      quo_next   [NST][LANES];

    always_comb begin
        logic [NST-1:0]    num_c;
        logic [DW-1:0]     rem_c;
        logic [NST-1:0]    quo_c;
        acn_pkg::dv_step_t st;
        for (int g = 0; g < NST; g++) begin
            valid_next[g] = (g == 0) ? in_valid : valid_reg[(g == 0) ? 0 : g - 1];
            side_next[g]  = (g == 0) ? side_in  : side_reg[(g == 0) ? 0 : g - 1];
            den_next[g]   = (g == 0) ? den_in   : den_reg[(g == 0) ? 0 : g - 1];
            for (int l = 0; l < LANES; l++) begin
                if (g == 0) begin
                    // quotient fits NST bits, so the top part is below the divisor
                    num_c = num_in[l][NST-1:0];
                    rem_c = num_in[l][NST+DW-1:NST];
                    quo_c = '0;
                end else begin
                    num_c = num_reg[g-1][l];
                    rem_c = rem_reg[g-1][l];
                    quo_c = quo_reg[g-1][l];
                end
                st = acn_pkg::div_step(rem_c, den_next[g], num_c[NST-1]);
                num_next[g][l] = num_c << 1;
                rem_next[g][l] = st.rem;
                quo_next[g][l] = {quo_c[NST-2:0], st.qbit};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g < NST; g++) valid_reg[g] <= 1'b0;
        end else if (adv) begin
            for (int g = 0; g < NST; g++) valid_reg[g] <= valid_next[g];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int g = 0; g < NST; g++) begin
                side_reg[g] <= side_next[g];
                den_reg[g]  <= den_next[g];
                for (int l = 0; l < LANES; l++) begin
                    num_reg[g][l] <= num_next[g][l];
                    rem_reg[g][l] <= rem_next[g][l];
                    quo_reg[g][l] <= quo_next[g][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign side_out  = side_reg[NST-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) quo_out[l] = quo_reg[NST-1][l];
    end

endmodule
